>>> hw/rtl/pre_pkg.sv
package pre_pkg;

  localparam int MaxProcesses       = 4;
  localparam int MaxPagesPerProcess = 128;
  localparam int PhysicalLocations  = 512;
  localparam int SizeRegs           = 4;

  localparam int PidW    = 2;
  localparam int PageW   = 7;
  localparam int PgW     = PidW + PageW;
  localparam int FrW     = $clog2(PhysicalLocations);
  localparam int FcW     = FrW + 1;
  localparam int NpW     = $clog2(MaxPagesPerProcess + 1);
  localparam int AddrW   = 13;
  localparam int StampW  = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 13;

  localparam logic [StampW-1:0] StampMax = '1;
  localparam logic [FcW-1:0]    NoFrame  = FcW'(PhysicalLocations);

  typedef enum logic [1:0] {
    PolFifo  = 2'd0,
    PolLru   = 2'd1,
    PolClock = 2'd2,
    PolRsvd  = 2'd3
  } policy_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPolicy    = 3'd0,
    RegPrepaging = 3'd1,
    RegPageLog2  = 3'd2,
    RegProcCount = 3'd3,
    RegSize0     = 3'd4,
    RegSize1     = 3'd5,
    RegSize2     = 3'd6,
    RegSize3     = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    OpIdle, OpClear, OpAccept, OpPreload, OpCheck, OpHit, OpLoad, OpLru,
    OpClkA, OpClkB, OpClkC, OpEvA, OpEvB, OpWrite, OpPpA, OpPpB, OpPush
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pre_done;
    logic bad;
    logic resident;
    logic free;
    logic pol_lru;
    logic pol_clock;
    logic lru_done;
    logic clk_stop;
    logic pp_go;
    logic pp_end;
    logic pp_found;
    logic out_free;
  } sts_t;

  // pages of a process: ceil(size / page size), capped
  function automatic logic [NpW-1:0] page_count(logic [AddrW-1:0] size, logic [2:0] l2);
    logic [AddrW:0] n;
    n = ((AddrW+1)'(size) + ((AddrW+1)'(1) << l2) - (AddrW+1)'(1)) >> l2;
    page_count = (n > (AddrW+1)'(MaxPagesPerProcess)) ? NpW'(MaxPagesPerProcess) : n[NpW-1:0];
  endfunction

  // locations per process at preload
  function automatic logic [FcW-1:0] per_process(logic [2:0] pc);
    case (pc)
      3'd1:    per_process = FcW'(PhysicalLocations);
      3'd2:    per_process = FcW'(PhysicalLocations / 2);
      3'd3:    per_process = FcW'(PhysicalLocations / 3);
      default: per_process = FcW'(PhysicalLocations / 4);
    endcase
  endfunction

endpackage

>>> hw/rtl/pre_req_if.sv
interface pre_req_if;
  import pre_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PidW-1:0]  process_id;
  logic [AddrW-1:0] address;

  modport source (output valid, mode, process_id, address, input ready);
  modport sink (input valid, mode, process_id, address, output ready);
endinterface

>>> hw/rtl/pre_rsp_if.sv
interface pre_rsp_if;
  import pre_pkg::*;
  logic              valid;
  logic              ready;
  logic              fault;
  logic              bad_request;
  logic              evicted_valid;
  logic [PidW-1:0]   evicted_process;
  logic [PageW-1:0]  evicted_page;
  logic              prepaged_valid;
  logic [PageW-1:0]  prepaged_page;
  logic [StampW-1:0] fault_count;

  modport source (output valid, fault, bad_request, evicted_valid, evicted_process,
                  evicted_page, prepaged_valid, prepaged_page, fault_count, input ready);
  modport sink (input valid, fault, bad_request, evicted_valid, evicted_process,
                evicted_page, prepaged_valid, prepaged_page, fault_count, output ready);
endinterface

>>> hw/rtl/pre_dpath.sv
module pre_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pre_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pre_pkg::CfgW-1:0] cfg_wdata_i,
  input  pre_pkg::cmd_t            cmd_i,
  output pre_pkg::sts_t            sts_o,
  input  logic                     in_mode_i,
  input  logic [pre_pkg::PidW-1:0] in_process_id_i,
  input  logic [pre_pkg::AddrW-1:0] in_address_i,
  pre_rsp_if.source                rsp
);
  import pre_pkg::*;

  // configuration
  logic [1:0]       pol_q;
  logic             pp_en_q;
  logic [2:0]       l2_q;
  logic [2:0]       pcnt_q;
  logic [AddrW-1:0] size_q [SizeRegs];

  // page tables and frame table
  logic              res_mem  [PhysicalLocations];
  logic              mark_mem [PhysicalLocations];
  logic [StampW-1:0] st_mem   [PhysicalLocations];
  logic [PgW-1:0]    own_mem  [PhysicalLocations];

  logic              res_rd_q, mark_rd_q;
  logic [StampW-1:0] st_rd_q;
  logic [PgW-1:0]    own_rd_q;

  logic res_we, mark_we, st_we, own_we;
  logic res_wd, mark_wd;
  logic [PgW-1:0] res_wa, mark_wa, st_wa, own_wd, pg_ra;
  logic [FrW-1:0] own_wa, own_ra;
  logic [StampW-1:0] st_wd;

  // control state
  logic [FrW-1:0]    cnt_q;
  logic [FcW-1:0]    fiu_q;
  logic [FrW-1:0]    vp_q;
  logic [StampW-1:0] uc_q, ft_q;
  logic              s1v_q, s2v_q, out_v_q;

  // working registers
  logic [PidW-1:0]   pid_q;
  logic [AddrW-1:0]  addr_q;
  logic [PageW-1:0]  page_q, q_q;
  logic [NpW-1:0]    npg_q, ppk_q, j_q;
  logic [PgW-1:0]    pg_q, ld_pg_q, cown_q;
  logic [FrW-1:0]    fr_q, fr1_q, wvp_q, s1f_q, s2f_q, best_q;
  logic [FcW-1:0]    excl_q, ia_q;
  logic [FcW:0]      k_q;
  logic [StampW-1:0] bt_q;
  logic              found_q, phase_q;
  logic [2:0]        p_q;
  logic              r_fault, r_bad, r_ev, r_ppv;
  logic [PidW-1:0]   r_evp;
  logic [PageW-1:0]  r_evpg, r_pppg;

  // output register
  logic              o_fault, o_bad, o_ev, o_ppv;
  logic [PidW-1:0]   o_evp;
  logic [PageW-1:0]  o_evpg, o_pppg;
  logic [StampW-1:0] o_fc;

  // derived values
  logic [2:0]        l2e, pce;
  logic [FcW-1:0]    fcnt, per;
  logic [FrW-1:0]    fmask, vp_eff, wvp_n, vp_fifo_n;
  logic [NpW-1:0]    npg_cur, npre;
  logic [AddrW-1:0]  page_full;
  logic [PgW-1:0]    pg_cur;
  logic [PageW-1:0]  q_n;
  logic [StampW-1:0] uc_inc, ft_inc;
  logic bad_cur, free, pre_done, pre_step, lru_take, lru_done, clk_stop, pp_end;
  logic is_lru, is_clock;

  assign l2e      = (l2_q > 3'd5) ? 3'd5 : l2_q;
  assign pce      = (pcnt_q == 3'd0) ? 3'd1 :
                    (pcnt_q > 3'(MaxProcesses)) ? 3'(MaxProcesses) : pcnt_q;
  assign fcnt     = FcW'(PhysicalLocations) >> l2e;
  assign fmask    = FrW'(fcnt - FcW'(1));
  assign per      = per_process(pce) >> l2e;
  assign npg_cur  = page_count(size_q[pid_q], l2e);
  assign npre     = page_count(size_q[p_q[PidW-1:0]], l2e);
  assign page_full = AddrW'(addr_q - AddrW'(1)) >> l2e;
  assign pg_cur   = {pid_q, page_full[PageW-1:0]};
  assign bad_cur  = ({1'b0, pid_q} >= pce) || (addr_q == '0) || (addr_q > size_q[pid_q]) ||
                    (page_full >= AddrW'(npg_cur));
  assign uc_inc   = (uc_q == StampMax) ? uc_q : uc_q + StampW'(1);
  assign ft_inc   = (ft_q == StampMax) ? ft_q : ft_q + StampW'(1);
  assign free     = fiu_q < fcnt;
  assign vp_eff   = (FcW'(vp_q) < fcnt) ? vp_q : '0;
  assign vp_fifo_n = FrW'(vp_eff + FrW'(1)) & fmask;
  assign wvp_n    = FrW'(wvp_q + FrW'(1)) & fmask;
  assign is_lru   = policy_e'(pol_q) == PolLru;
  assign is_clock = policy_e'(pol_q) == PolClock;
  assign pre_done = p_q == pce;
  assign pre_step = (j_q < npre) && (FcW'(j_q) < per) && (fiu_q < fcnt);
  assign lru_take = s2v_q && ({1'b0, s2f_q} != excl_q) && (!found_q || st_rd_q < bt_q);
  assign lru_done = (ia_q == fcnt) && !s1v_q && !s2v_q;
  assign clk_stop = (k_q == {fcnt, 1'b0}) || !mark_rd_q;
  assign q_n      = ((NpW'(q_q) + NpW'(1)) == npg_q) ? '0 : PageW'(q_q + PageW'(1));
  assign pp_end   = ppk_q == npg_q;

  // status to the controller
  assign sts_o.clr_last  = &cnt_q;
  assign sts_o.pre_done  = pre_done;
  assign sts_o.bad       = bad_cur;
  assign sts_o.resident  = res_rd_q;
  assign sts_o.free      = free;
  assign sts_o.pol_lru   = is_lru;
  assign sts_o.pol_clock = is_clock;
  assign sts_o.lru_done  = lru_done;
  assign sts_o.clk_stop  = clk_stop;
  assign sts_o.pp_go     = !phase_q && pp_en_q && (npg_q > NpW'(1));
  assign sts_o.pp_end    = pp_end;
  assign sts_o.pp_found  = !res_rd_q;
  assign sts_o.out_free  = !out_v_q || rsp.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q   <= PolFifo;
      pp_en_q <= 1'b0;
      l2_q    <= 3'd0;
      pcnt_q  <= 3'd1;
      for (int i = 0; i < SizeRegs; i++) size_q[i] <= AddrW'(1);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        RegPolicy:    pol_q   <= cfg_wdata_i[1:0];
        RegPrepaging: pp_en_q <= cfg_wdata_i[0];
        RegPageLog2:  l2_q    <= cfg_wdata_i[2:0];
        RegProcCount: pcnt_q  <= cfg_wdata_i[2:0];
        RegSize0:     size_q[0] <= cfg_wdata_i;
        RegSize1:     size_q[1] <= cfg_wdata_i;
        RegSize2:     size_q[2] <= cfg_wdata_i;
        RegSize3:     size_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // read addresses
  always_comb begin
    case (cmd_i.op)
      OpClkA:  own_ra = wvp_q;
      OpClkC:  own_ra = wvp_n;
      OpEvA:   own_ra = fr_q;
      default: own_ra = ia_q[FrW-1:0];
    endcase
    case (cmd_i.op)
      OpLru, OpClkB: pg_ra = own_rd_q;
      OpPpA:         pg_ra = {pid_q, q_n};
      default:       pg_ra = pg_cur;
    endcase
  end

  // write ports
  always_comb begin
    res_we = 1'b0; res_wa = ld_pg_q; res_wd = 1'b1;
    mark_we = 1'b0; mark_wa = ld_pg_q; mark_wd = 1'b1;
    st_we = 1'b0; st_wa = ld_pg_q; st_wd = uc_q;
    own_we = 1'b0; own_wa = fr_q; own_wd = ld_pg_q;
    case (cmd_i.op)
      OpClear: begin
        res_we = 1'b1; res_wa = cnt_q; res_wd = 1'b0;
        mark_we = 1'b1; mark_wa = cnt_q; mark_wd = 1'b0;
        st_we = 1'b1; st_wa = cnt_q; st_wd = '0;
      end
      OpPreload: begin
        if (!pre_done && pre_step) begin
          res_we = 1'b1; res_wa = {p_q[PidW-1:0], j_q[PageW-1:0]};
          own_we = 1'b1; own_wa = fiu_q[FrW-1:0];
          own_wd = {p_q[PidW-1:0], j_q[PageW-1:0]};
        end
      end
      OpCheck: begin
        st_we = !bad_cur; st_wa = pg_cur; st_wd = uc_inc;
      end
      OpHit: begin
        mark_we = res_rd_q; mark_wa = pg_q;
      end
      OpClkC: begin
        mark_we = !clk_stop; mark_wa = cown_q; mark_wd = 1'b0;
      end
      OpEvB: begin
        res_we = 1'b1; res_wa = own_rd_q; res_wd = 1'b0;
      end
      OpWrite: begin
        res_we = 1'b1; mark_we = 1'b1; st_we = 1'b1; own_we = 1'b1;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (st_we) st_mem[st_wa] <= st_wd;
    if (own_we) own_mem[own_wa] <= own_wd;
    res_rd_q  <= res_mem[pg_ra];
    mark_rd_q <= mark_mem[pg_ra];
    st_rd_q   <= st_mem[pg_ra];
    own_rd_q  <= own_mem[own_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; fiu_q <= '0; vp_q <= '0; uc_q <= '0; ft_q <= '0;
      s1v_q <= 1'b0; s2v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      // hold the result until it is taken
      if (cmd_i.op == OpPush) out_v_q <= 1'b1;
      else if (rsp.ready) out_v_q <= 1'b0;
      case (cmd_i.op)
        OpClear: cnt_q <= cnt_q + FrW'(1);
        OpAccept: begin
          if (!in_mode_i) begin
            fiu_q <= '0; vp_q <= '0; uc_q <= '0; ft_q <= '0; cnt_q <= '0;
          end
        end
        OpPreload: if (!pre_done && pre_step) fiu_q <= fiu_q + FcW'(1);
        OpCheck:   if (!bad_cur) uc_q <= uc_inc;
        OpHit:     if (!res_rd_q) ft_q <= ft_inc;
        OpLoad: begin
          if (free) fiu_q <= fiu_q + FcW'(1);
          else if (is_lru) begin
            s1v_q <= 1'b0; s2v_q <= 1'b0;
          end else if (!is_clock) vp_q <= vp_fifo_n;
        end
        OpLru: begin
          s1v_q <= ia_q < fcnt;
          s2v_q <= s1v_q;
        end
        OpClkC: if (clk_stop) vp_q <= wvp_n;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpAccept: begin
        pid_q <= in_process_id_i; addr_q <= in_address_i;
        r_fault <= 1'b0; r_bad <= 1'b0; r_ev <= 1'b0; r_ppv <= 1'b0;
        r_evp <= '0; r_evpg <= '0; r_pppg <= '0;
        p_q <= '0; j_q <= '0;
      end
      OpPreload: begin
        if (!pre_done) begin
          if (pre_step) j_q <= j_q + NpW'(1);
          else begin
            p_q <= p_q + 3'd1; j_q <= '0;
          end
        end
      end
      OpCheck: begin
        page_q <= page_full[PageW-1:0]; npg_q <= npg_cur; pg_q <= pg_cur; r_bad <= bad_cur;
      end
      OpHit: begin
        ld_pg_q <= pg_q; excl_q <= NoFrame; phase_q <= 1'b0;
      end
      OpLoad: begin
        if (free) fr_q <= fiu_q[FrW-1:0];
        else if (is_lru) begin
          ia_q <= '0; found_q <= 1'b0;
        end else if (is_clock) begin
          wvp_q <= vp_eff; k_q <= '0;
        end else fr_q <= vp_eff;
      end
      OpLru: begin
        ia_q  <= ia_q + FcW'(ia_q < fcnt);
        s1f_q <= ia_q[FrW-1:0];
        s2f_q <= s1f_q;
        if (lru_take) begin
          best_q <= s2f_q; bt_q <= st_rd_q; found_q <= 1'b1;
        end
        if (lru_done) fr_q <= best_q;
      end
      OpClkB: cown_q <= own_rd_q;
      OpClkC: begin
        if (clk_stop) fr_q <= wvp_q;
        else begin
          wvp_q <= wvp_n; k_q <= k_q + (FcW+1)'(1);
        end
      end
      OpEvB: begin
        if (!phase_q) begin
          r_ev <= 1'b1; r_evp <= own_rd_q[PgW-1:PageW]; r_evpg <= own_rd_q[PageW-1:0];
        end
      end
      OpWrite: begin
        if (!phase_q) begin
          r_fault <= 1'b1; fr1_q <= fr_q; q_q <= page_q; ppk_q <= NpW'(1);
        end else begin
          r_ppv <= 1'b1; r_pppg <= q_q;
        end
      end
      OpPpA: begin
        if (!pp_end) begin
          q_q <= q_n; ppk_q <= ppk_q + NpW'(1);
        end
      end
      OpPpB: begin
        if (!res_rd_q) begin
          ld_pg_q <= {pid_q, q_q}; excl_q <= {1'b0, fr1_q}; phase_q <= 1'b1;
        end
      end
      OpPush: begin
        o_fault <= r_fault; o_bad <= r_bad; o_ev <= r_ev; o_evp <= r_evp;
        o_evpg <= r_evpg; o_ppv <= r_ppv; o_pppg <= r_pppg; o_fc <= ft_q;
      end
      default: ;
    endcase
  end

  assign rsp.valid           = out_v_q;
  assign rsp.fault           = o_fault;
  assign rsp.bad_request     = o_bad;
  assign rsp.evicted_valid   = o_ev;
  assign rsp.evicted_process = o_evp;
  assign rsp.evicted_page    = o_evpg;
  assign rsp.prepaged_valid  = o_ppv;
  assign rsp.prepaged_page   = o_pppg;
  assign rsp.fault_count     = o_fc;

endmodule

>>> hw/rtl/pre_ctrl.sv
module pre_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_start_i,
  output logic          in_ready_o,
  input  pre_pkg::sts_t sts_i,
  output pre_pkg::cmd_t cmd_o
);
  import pre_pkg::*;

  typedef enum logic [16:0] {
    StRclr  = 17'h00001,
    StIdle  = 17'h00002,
    StSclr  = 17'h00004,
    StPre   = 17'h00008,
    StChk   = 17'h00010,
    StHit   = 17'h00020,
    StLoad  = 17'h00040,
    StLru   = 17'h00080,
    StClkA  = 17'h00100,
    StClkB  = 17'h00200,
    StClkC  = 17'h00400,
    StEvA   = 17'h00800,
    StEvB   = 17'h01000,
    StWrite = 17'h02000,
    StPpA   = 17'h04000,
    StPpB   = 17'h08000,
    StDone  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // sequence the datapath
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OpIdle;
    in_ready_o = 1'b0;
    unique case (state_q)
      StRclr: begin
        cmd_o.op = OpClear;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OpAccept;
          state_d  = in_start_i ? StSclr : StChk;
        end
      end
      StSclr: begin
        cmd_o.op = OpClear;
        if (sts_i.clr_last) state_d = StPre;
      end
      StPre: begin
        cmd_o.op = OpPreload;
        if (sts_i.pre_done) state_d = StDone;
      end
      StChk: begin
        cmd_o.op = OpCheck;
        state_d  = sts_i.bad ? StDone : StHit;
      end
      StHit: begin
        cmd_o.op = OpHit;
        state_d  = sts_i.resident ? StDone : StLoad;
      end
      StLoad: begin
        cmd_o.op = OpLoad;
        if (sts_i.free) state_d = StWrite;
        else if (sts_i.pol_lru) state_d = StLru;
        else if (sts_i.pol_clock) state_d = StClkA;
        else state_d = StEvA;
      end
      StLru: begin
        cmd_o.op = OpLru;
        if (sts_i.lru_done) state_d = StEvA;
      end
      StClkA: begin
        cmd_o.op = OpClkA;
        state_d  = StClkB;
      end
      StClkB: begin
        cmd_o.op = OpClkB;
        state_d  = StClkC;
      end
      StClkC: begin
        cmd_o.op = OpClkC;
        state_d  = sts_i.clk_stop ? StEvA : StClkB;
      end
      StEvA: begin
        cmd_o.op = OpEvA;
        state_d  = StEvB;
      end
      StEvB: begin
        cmd_o.op = OpEvB;
        state_d  = StWrite;
      end
      StWrite: begin
        cmd_o.op = OpWrite;
        state_d  = sts_i.pp_go ? StPpA : StDone;
      end
      StPpA: begin
        cmd_o.op = OpPpA;
        state_d  = sts_i.pp_end ? StDone : StPpB;
      end
      StPpB: begin
        cmd_o.op = OpPpB;
        state_d  = sts_i.pp_found ? StLoad : StPpA;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.op = OpPush;
          state_d  = StIdle;
        end
      end
      default: state_d = StRclr;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRclr;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/page_replacement_engine_unit.sv
// Demand-paging engine for up to four processes over 512 physical locations.
// After reset the page tables are cleared in one pass over all 512 entries,
// during which no transaction is taken (configuration writes still are).
// A start transaction clears the tables and then preloads frames for each
// process in use. An access is checked, then looked up, and on a fault loaded
// into a free frame or over a victim chosen under FIFO, LRU or Clock. With F
// frames, LRU scans the frame table through a pipelined read of owner and time
// stamp; Clock examines up to 2F + 1 frames. With prepaging the search for the
// next absent page follows the load, and the extra load repeats the victim
// search. One transaction is in flight at a time; a finished result waits in
// an output register.
module page_replacement_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pre_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pre_pkg::CfgW-1:0]     cfg_wdata_i,
  pre_req_if.sink                      req_i,
  pre_rsp_if.source                    rsp_o
);
  import pre_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_i.ready = in_ready;

  // sequencer
  pre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_start_i (!req_i.mode),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables, counters and result register
  pre_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_mode_i       (req_i.mode),
    .in_process_id_i (req_i.process_id),
    .in_address_i    (req_i.address),
    .rsp             (rsp_o)
  );

`ifndef NO_ASSERTIONS
  a_evict_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.evicted_valid |-> rsp_o.fault)
    else $error("eviction reported without a fault");

  a_prepage_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.prepaged_valid |-> rsp_o.fault)
    else $error("prepage reported without a fault");

  a_bad_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.bad_request |-> !rsp_o.fault)
    else $error("bad request reported as a fault");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("second transaction taken while one is in flight");
`endif

endmodule

>>> dv/page_table_checker.sv
// Watches the configuration port and both channels, keeps its own copy of the
// page tables and compares every response transaction with the prediction.
module page_table_checker
  import pre_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  pre_req_if                 req_i,
  pre_rsp_if                 rsp_i,
  output int                 fails_o,
  output int                 pending_o
);

  localparam int unsigned TotalPages = MaxProcesses * MaxPagesPerProcess;
  localparam int          ReportMax  = 10;

  typedef struct packed {
    logic              fault;
    logic              bad_request;
    logic              evicted_valid;
    logic [PidW-1:0]   evicted_process;
    logic [PageW-1:0]  evicted_page;
    logic              prepaged_valid;
    logic [PageW-1:0]  prepaged_page;
    logic [StampW-1:0] fault_count;
  } paging_rsp_t;

  // shadow configuration
  policy_e          cfg_policy;
  logic             cfg_prepage;
  logic [2:0]       cfg_l2;
  logic [2:0]       cfg_pcount;
  logic [AddrW-1:0] cfg_size [SizeRegs];

  // shadow page tables
  logic              resident  [TotalPages];
  logic              used_mark [TotalPages];
  logic [StampW-1:0] last_use  [TotalPages];
  logic [PgW-1:0]    owner     [PhysicalLocations];
  int unsigned       frames_used, victim_ptr;
  logic [StampW-1:0] use_clk, fault_tot;

  paging_rsp_t expected_rsp_q [$];
  int          mismatches;

  assign fails_o = mismatches;

  function automatic int unsigned page_shift();
    return (cfg_l2 > 3'd5) ? 5 : int'(cfg_l2);
  endfunction

  function automatic int unsigned live_procs();
    int unsigned c;
    c = (cfg_pcount == 3'd0) ? 1 : int'(cfg_pcount);
    if (c > MaxProcesses) c = MaxProcesses;
    if (c > SizeRegs) c = SizeRegs;
    return c;
  endfunction

  function automatic int unsigned frame_total();
    return PhysicalLocations >> page_shift();
  endfunction

  function automatic int unsigned pages_of(input int unsigned p);
    int unsigned ps, n;
    ps = 1 << page_shift();
    n  = (int'(cfg_size[p]) + ps - 1) >> page_shift();
    return (n > MaxPagesPerProcess) ? MaxPagesPerProcess : n;
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < TotalPages; i++) begin
      resident[i]  = 1'b0;
      used_mark[i] = 1'b0;
      last_use[i]  = '0;
    end
    frames_used = 0;
    victim_ptr  = 0;
    use_clk     = '0;
    fault_tot   = '0;
  endtask

  // place a page in a free frame or over the chosen victim
  task automatic place_page(input int unsigned pg, input int unsigned excl,
                            output bit ev, output int unsigned evo,
                            output int unsigned fr);
    int unsigned nf, used, vp, best, o;
    logic [StampW-1:0] bt, t;
    bit found;
    nf  = frame_total();
    used = (frames_used < nf) ? frames_used : nf;
    ev  = 1'b0;
    evo = 0;
    if (used < nf) begin
      fr = used;
      frames_used = used + 1;
    end else begin
      vp = (victim_ptr < nf) ? victim_ptr : 0;
      if (cfg_policy == PolLru) begin
        found = 1'b0;
        best  = 0;
        bt    = '0;
        for (int f = 0; f < nf; f++) begin
          if (f != excl) begin
            t = last_use[owner[f]];
            if (!found || t < bt) begin
              found = 1'b1;
              bt    = t;
              best  = f;
            end
          end
        end
        fr = best;
      end else if (cfg_policy == PolClock) begin
        for (int k = 0; k < 2 * nf; k++) begin
          o = owner[vp];
          if (!used_mark[o]) break;
          used_mark[o] = 1'b0;
          vp = (vp + 1) % nf;
        end
        fr = vp;
        victim_ptr = (vp + 1) % nf;
      end else begin
        fr = vp;
        victim_ptr = (vp + 1) % nf;
      end
      evo = owner[fr];
      ev  = 1'b1;
      resident[evo] = 1'b0;
    end
    owner[fr]     = PgW'(pg);
    resident[pg]  = 1'b1;
    used_mark[pg] = 1'b1;
    last_use[pg]  = use_clk;
  endtask

  // work out the response of one request transaction and update the tables
  task automatic predict_paging(input logic mode, input logic [PidW-1:0] pid,
                                input logic [AddrW-1:0] addr, output paging_rsp_t r);
    int unsigned pc, per, nf, n, np, page, pg, fr, q, qg, evo, evo2, fr2;
    bit ev, ev2;
    r = '0;
    if (!mode) begin
      pc  = live_procs();
      per = (PhysicalLocations / pc) >> page_shift();
      nf  = frame_total();
      clear_tables();
      for (int p = 0; p < pc; p++) begin
        n = pages_of(p);
        for (int j = 0; j < n && j < per && frames_used < nf; j++) begin
          pg = p * MaxPagesPerProcess + j;
          owner[frames_used] = PgW'(pg);
          frames_used++;
          resident[pg] = 1'b1;
        end
      end
      return;
    end
    if (pid >= live_procs() || addr == '0 || addr > cfg_size[pid]) begin
      r.bad_request = 1'b1;
      r.fault_count = fault_tot;
      return;
    end
    np   = pages_of(pid);
    page = (int'(addr) - 1) >> page_shift();
    if (page >= np) begin
      r.bad_request = 1'b1;
      r.fault_count = fault_tot;
      return;
    end
    if (use_clk != StampMax) use_clk++;
    pg = int'(pid) * MaxPagesPerProcess + page;
    last_use[pg] = use_clk;
    if (resident[pg]) begin
      used_mark[pg] = 1'b1;
      r.fault_count = fault_tot;
      return;
    end
    if (fault_tot != StampMax) fault_tot++;
    place_page(pg, PhysicalLocations, ev, evo, fr);
    r.fault = 1'b1;
    if (ev) begin
      r.evicted_valid   = 1'b1;
      r.evicted_process = PidW'(evo / MaxPagesPerProcess);
      r.evicted_page    = PageW'(evo % MaxPagesPerProcess);
    end
    // prepage the next absent page of the same process, wrapping
    if (cfg_prepage && frame_total() >= 2 && np > 1) begin
      q = page;
      for (int k = 1; k < np; k++) begin
        q  = (q + 1 == np) ? 0 : q + 1;
        qg = int'(pid) * MaxPagesPerProcess + q;
        if (!resident[qg]) begin
          place_page(qg, fr, ev2, evo2, fr2);
          r.prepaged_valid = 1'b1;
          r.prepaged_page  = PageW'(q);
          break;
        end
      end
    end
    r.fault_count = fault_tot;
  endtask

  task automatic note_field(input string name, input logic [StampW-1:0] exp_v,
                            input logic [StampW-1:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < ReportMax)
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    paging_rsp_t exp_r;
    paging_rsp_t new_r;
    if (!rst_ni) begin
      cfg_policy  = PolFifo;
      cfg_prepage = 1'b0;
      cfg_l2      = 3'd0;
      cfg_pcount  = 3'd1;
      for (int i = 0; i < SizeRegs; i++) cfg_size[i] = AddrW'(1);
      clear_tables();
      expected_rsp_q.delete();
      mismatches = 0;
    end else begin
      // compare the response transaction with the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsp_q.size() == 0) begin
          if (mismatches < ReportMax)
            $display("%0t: response with none outstanding", $realtime);
          mismatches++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          note_field("fault", exp_r.fault, rsp_i.fault);
          note_field("bad_request", exp_r.bad_request, rsp_i.bad_request);
          note_field("evicted_valid", exp_r.evicted_valid, rsp_i.evicted_valid);
          note_field("evicted_process", exp_r.evicted_process, rsp_i.evicted_process);
          note_field("evicted_page", exp_r.evicted_page, rsp_i.evicted_page);
          note_field("prepaged_valid", exp_r.prepaged_valid, rsp_i.prepaged_valid);
          note_field("prepaged_page", exp_r.prepaged_page, rsp_i.prepaged_page);
          note_field("fault_count", exp_r.fault_count, rsp_i.fault_count);
        end
      end
      // track register writes
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          RegPolicy:    cfg_policy  = policy_e'(cfg_wdata_i[1:0]);
          RegPrepaging: cfg_prepage = cfg_wdata_i[0];
          RegPageLog2:  cfg_l2      = cfg_wdata_i[2:0];
          RegProcCount: cfg_pcount  = cfg_wdata_i[2:0];
          RegSize0:     cfg_size[0] = cfg_wdata_i;
          RegSize1:     cfg_size[1] = cfg_wdata_i;
          RegSize2:     cfg_size[2] = cfg_wdata_i;
          RegSize3:     cfg_size[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      // predict each request transaction
      if (req_i.valid && req_i.ready) begin
        predict_paging(req_i.mode, req_i.process_id, req_i.address, new_r);
        expected_rsp_q = {expected_rsp_q, new_r};
      end
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

>>> dv/tb_page_replacement_engine_unit.sv
module tb_page_replacement_engine_unit;
  import pre_pkg::*;

  localparam logic ModeStart     = 1'b0;
  localparam logic ModeAccess    = 1'b1;
  localparam int   ItemTarget    = 570;
  localparam int   QuietFrom     = 500;
  localparam int   HoldCycles    = 400;
  localparam int   WatchdogLimit = 20000;
  localparam int   TailCycles    = 64;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  pre_req_if req_if ();
  pre_rsp_if rsp_if ();

  int fails;
  int pending;
  int items_sent;
  int stall_cycles = 0;
  bit quiet;
  bit hold_req;

  // stimulus-side view of the configuration
  int unsigned      live_pc, shift;
  logic [AddrW-1:0] sizes [SizeRegs];

  page_replacement_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  page_table_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        rsp_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_e idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] pol, input logic pp, input logic [2:0] l2,
                            input logic [2:0] pc, input logic [AddrW-1:0] s0,
                            input logic [AddrW-1:0] s1, input logic [AddrW-1:0] s2,
                            input logic [AddrW-1:0] s3);
    write_reg(RegPolicy, CfgW'(pol));
    write_reg(RegPrepaging, CfgW'(pp));
    write_reg(RegPageLog2, CfgW'(l2));
    write_reg(RegProcCount, CfgW'(pc));
    write_reg(RegSize0, s0);
    write_reg(RegSize1, s1);
    write_reg(RegSize2, s2);
    write_reg(RegSize3, s3);
    cfg_we <= 1'b0;
    live_pc = (pc == 3'd0) ? 1 : ((pc > 3'd4) ? 4 : int'(pc));
    shift   = (l2 > 3'd5) ? 5 : int'(l2);
    sizes[0] = s0;
    sizes[1] = s1;
    sizes[2] = s2;
    sizes[3] = s3;
  endtask

  // offer one transaction and hold it until taken
  task automatic send_item(input logic mode, input logic [PidW-1:0] pid,
                           input logic [AddrW-1:0] addr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.process_id <= pid;
    req_if.address    <= addr;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // drain all outstanding responses before touching registers
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return AddrW'(4096);
      1:       return AddrW'($urandom_range(1, 64));
      default: return AddrW'($urandom_range(1, 4096));
    endcase
  endfunction

  // mostly legal accesses with locality, some malformed ones
  task automatic run_accesses(input int count);
    logic [PidW-1:0]  pid, last_pid;
    logic [AddrW-1:0] addr, last_addr;
    int unsigned      r, span;
    last_pid  = '0;
    last_addr = AddrW'(1);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        pid = PidW'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0:       addr = '0;
          1:       addr = (sizes[pid] < 13'h1fff) ?
                          AddrW'($urandom_range(int'(sizes[pid]) + 1, 8191)) : '0;
          2:       addr = AddrW'($urandom_range(0, 8191));
          default: addr = '1;
        endcase
      end else if (r < 35) begin
        pid  = last_pid;
        addr = last_addr;
      end else begin
        pid  = PidW'($urandom_range(0, live_pc - 1));
        span = int'(sizes[pid]);
        if (r < 70 && span > (6 << shift)) span = 6 << shift;
        addr = AddrW'($urandom_range(1, span));
      end
      send_item(ModeAccess, pid, addr);
      last_pid  = pid;
      last_addr = addr;
    end
  endtask

  initial begin
    int phase;
    int unsigned l2_raw;
    req_if.valid      = 1'b0;
    req_if.mode       = ModeStart;
    req_if.process_id = '0;
    req_if.address    = '0;
    cfg_we            = 1'b0;
    cfg_idx           = RegPolicy;
    cfg_wdata         = '0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    items_sent        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: LRU with prepaging, sixteen frames, four processes
    set_config(PolLru, 1'b1, 3'd5, 3'd4, 13'd4096, 13'd1, 13'd100, 13'd33);
    send_item(ModeStart, 2'd0, 13'd0);
    send_item(ModeAccess, 2'd0, 13'd1);
    send_item(ModeAccess, 2'd0, 13'd4096);
    send_item(ModeAccess, 2'd1, 13'd1);
    send_item(ModeAccess, 2'd1, 13'd2);
    send_item(ModeAccess, 2'd0, 13'd0);
    send_item(ModeAccess, 2'd3, 13'd34);
    send_item(ModeAccess, 2'd3, 13'd33);
    send_item(ModeAccess, 2'd2, 13'h1fff);
    for (int k = 1; k <= 10; k++) send_item(ModeAccess, 2'd0, AddrW'(k * 390));
    send_item(ModeStart, 2'd3, 13'h1fff);
    settle();

    // directed: clock, oversized page register, zero process count
    set_config(PolClock, 1'b1, 3'd7, 3'd0, 13'd200, 13'd64, 13'd1, 13'd1);
    send_item(ModeStart, 2'd0, 13'd0);
    send_item(ModeAccess, 2'd1, 13'd1);
    for (int k = 0; k < 4; k++) send_item(ModeAccess, 2'd0, AddrW'(1 + k * 50));
    settle();

    // random phases across the configuration space
    phase = 0;
    while (items_sent < ItemTarget) begin
      l2_raw = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 7) : $urandom_range(0, 2);
      if (phase == 1) l2_raw = 0;
      set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 3'(l2_raw),
                 3'($urandom_range(0, 7)), pick_size(), pick_size(), pick_size(),
                 pick_size());
      if (items_sent >= QuietFrom) quiet = 1'b1;
      if (phase == 2) hold_req = 1'b1;
      if ($urandom_range(0, 4) != 0) send_item(ModeStart, 2'($urandom_range(0, 3)),
                                              13'($urandom_range(0, 8191)));
      run_accesses($urandom_range(30, 50));
      settle();
      phase++;
    end

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pre_pkg.sv
hw/rtl/pre_req_if.sv
hw/rtl/pre_rsp_if.sv
hw/rtl/pre_dpath.sv
hw/rtl/pre_ctrl.sv
hw/rtl/page_replacement_engine_unit.sv
dv/page_table_checker.sv
dv/tb_page_replacement_engine_unit.sv
